@@ src/fcmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcmc_pkg
// Shared types, codes and constants of the single-precision compare unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fcmc_pkg;

    typedef enum logic [2:0] {
        OP_FEQ    = 3'd0,
        OP_FLT    = 3'd1,
        OP_FLE    = 3'd2,
        OP_FMIN   = 3'd3,
        OP_FMAX   = 3'd4,
        OP_FCLASS = 3'd5
    } op_t;

    localparam logic [7:0]  EXP_ONES     = 8'hff;
    localparam logic [31:0] CANON_NAN    = 32'h7fc00000;
    localparam logic [4:0]  FLAG_INVALID = 5'd16;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic [4:0]  fflags;
    } out_item_t;

    // Decoded operand properties, produced by stage one.
    typedef struct packed {
        logic        sign;
        logic        exp_ones;
        logic        exp_zero;
        logic        frac_zero;
        logic        quiet;
    } opnd_info_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        opnd_info_t  info_a;
        opnd_info_t  info_b;
    } dec_t;

    // Compare facts, produced by stage two.
    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic        a_nan;
        logic        b_nan;
        logic        any_snan;
        logic        equal;
        logic        less_num;
        logic        less_total;
        logic [9:0]  class_mask;
    } cmp_t;

endpackage
`default_nettype wire

@@ src/fcmc_stream_if.sv @@
// ----------------------------------------------------------------------------
// fcmc_stream_if
// Valid/ready channel carrying one item of a generic payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface fcmc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/fcmc_decode.sv @@
// ----------------------------------------------------------------------------
// fcmc_decode
// Stage one: splits both operands into sign, exponent and fraction facts.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmc_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire fcmc_pkg::in_item_t in_item,
    input  wire logic              advance,
    output logic                   dec_valid_reg,
    output fcmc_pkg::dec_t         dec_reg
);

    function automatic fcmc_pkg::opnd_info_t info_of(input logic [31:0] v);
        fcmc_pkg::opnd_info_t r;
        r.sign      = v[31];
        r.exp_ones  = (v[30:23] == fcmc_pkg::EXP_ONES);
        r.exp_zero  = (v[30:23] == 8'd0);
        r.frac_zero = (v[22:0] == 23'd0);
        r.quiet     = v[22];
        return r;
    endfunction

    fcmc_pkg::dec_t dec_next;

    always_comb
    begin
        dec_next.operation = in_item.operation;
        dec_next.operand_a = in_item.operand_a;
        dec_next.operand_b = in_item.operand_b;
        dec_next.info_a    = info_of(in_item.operand_a);
        dec_next.info_b    = info_of(in_item.operand_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dec_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dec_reg <= dec_next;
        end
    end

endmodule
`default_nettype wire

@@ src/fcmc_compare.sv @@
// ----------------------------------------------------------------------------
// fcmc_compare
// Stage two: magnitude compare, NaN detection and class mask.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmc_compare (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           dec_valid,
    input  wire fcmc_pkg::dec_t dec,
    input  wire logic           advance,
    output logic                cmp_valid_reg,
    output fcmc_pkg::cmp_t      cmp_reg
);

    fcmc_pkg::cmp_t cmp_next;
    logic a_nan;
    logic b_nan;
    logic both_zero;
    logic mag_lt;
    logic mag_eq;
    logic sa;
    logic sb;

    always_comb
    begin
        a_nan     = dec.info_a.exp_ones && !dec.info_a.frac_zero;
        b_nan     = dec.info_b.exp_ones && !dec.info_b.frac_zero;
        both_zero = (dec.operand_a[30:0] == 31'd0) && (dec.operand_b[30:0] == 31'd0);
        mag_lt    = dec.operand_a[30:0] < dec.operand_b[30:0];
        mag_eq    = dec.operand_a == dec.operand_b;
        sa        = dec.info_a.sign;
        sb        = dec.info_b.sign;

        cmp_next.operation = dec.operation;
        cmp_next.operand_a = dec.operand_a;
        cmp_next.operand_b = dec.operand_b;
        cmp_next.a_nan     = a_nan;
        cmp_next.b_nan     = b_nan;
        cmp_next.any_snan  = (a_nan && !dec.info_a.quiet) || (b_nan && !dec.info_b.quiet);
        cmp_next.equal     = mag_eq || both_zero;
        if (sa != sb)
        begin
            cmp_next.less_num   = sa && !both_zero;
            cmp_next.less_total = sa;
        end
        else
        begin
            cmp_next.less_num   = !mag_eq && (sa != mag_lt);
            cmp_next.less_total = !mag_eq && (sa != mag_lt);
        end

        cmp_next.class_mask = 10'd0;
        if (dec.info_a.exp_ones)
        begin
            if (dec.info_a.frac_zero)
            begin
                cmp_next.class_mask[sa ? 0 : 7] = 1'b1;
            end
            else
            begin
                cmp_next.class_mask[dec.info_a.quiet ? 9 : 8] = 1'b1;
            end
        end
        else if (dec.info_a.exp_zero)
        begin
            if (dec.info_a.frac_zero)
            begin
                cmp_next.class_mask[sa ? 3 : 4] = 1'b1;
            end
            else
            begin
                cmp_next.class_mask[sa ? 2 : 5] = 1'b1;
            end
        end
        else
        begin
            cmp_next.class_mask[sa ? 1 : 6] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cmp_valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmp_reg <= cmp_next;
        end
    end

endmodule
`default_nettype wire

@@ src/fcmc_select.sv @@
// ----------------------------------------------------------------------------
// fcmc_select
// Stage three: picks the result and flags for the operation.
// ----------------------------------------------------------------------------
`default_nettype none
module fcmc_select (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmp_valid,
    input  wire fcmc_pkg::cmp_t cmp,
    input  wire logic           advance,
    output logic                out_valid_reg,
    output fcmc_pkg::out_item_t out_reg
);

    fcmc_pkg::out_item_t out_next;
    logic any_nan;

    always_comb
    begin
        any_nan         = cmp.a_nan || cmp.b_nan;
        out_next.result = 32'd0;
        out_next.fflags = 5'd0;
        case (cmp.operation)
            fcmc_pkg::OP_FEQ:
            begin
                if (any_nan)
                begin
                    out_next.fflags = cmp.any_snan ? fcmc_pkg::FLAG_INVALID : 5'd0;
                end
                else
                begin
                    out_next.result = {31'd0, cmp.equal};
                end
            end
            fcmc_pkg::OP_FLT, fcmc_pkg::OP_FLE:
            begin
                if (any_nan)
                begin
                    out_next.fflags = fcmc_pkg::FLAG_INVALID;
                end
                else if (cmp.operation == fcmc_pkg::OP_FLT)
                begin
                    out_next.result = {31'd0, cmp.less_num};
                end
                else
                begin
                    out_next.result = {31'd0, cmp.equal || cmp.less_num};
                end
            end
            fcmc_pkg::OP_FMIN, fcmc_pkg::OP_FMAX:
            begin
                out_next.fflags = cmp.any_snan ? fcmc_pkg::FLAG_INVALID : 5'd0;
                if (cmp.a_nan && cmp.b_nan)
                begin
                    out_next.result = fcmc_pkg::CANON_NAN;
                end
                else if (cmp.a_nan)
                begin
                    out_next.result = cmp.operand_b;
                end
                else if (cmp.b_nan)
                begin
                    out_next.result = cmp.operand_a;
                end
                else if ((cmp.operation == fcmc_pkg::OP_FMIN) == cmp.less_total)
                begin
                    out_next.result = cmp.operand_a;
                end
                else
                begin
                    out_next.result = cmp.operand_b;
                end
            end
            fcmc_pkg::OP_FCLASS:
            begin
                out_next.result = {22'd0, cmp.class_mask};
            end
            default:
            begin
                out_next.result = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cmp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

@@ src/fp32_compare_minmax_classify_top.sv @@
// ----------------------------------------------------------------------------
// fp32_compare_minmax_classify_top
// An accepted item passes the decode, compare and select registers before it reaches the output.
// Throughput: one item per cycle while the output is not stalled, set by the three-stage pipeline.
// A stalled output holds every stage; stages advance together when ready.
// Reset clears all valid bits; the payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module fp32_compare_minmax_classify_top (
    input  wire logic clk,
    input  wire logic rst_n,
    fcmc_stream_if.sink   in_ch,
    fcmc_stream_if.source out_ch
);

    logic                dec_valid;
    fcmc_pkg::dec_t      dec;
    logic                cmp_valid;
    fcmc_pkg::cmp_t      cmp;
    logic                out_valid;
    fcmc_pkg::out_item_t out_item;
    fcmc_pkg::in_item_t  in_item;
    logic                advance;

    assign advance         = out_ch.ready || !out_valid;
    assign in_ch.ready     = advance;
    assign in_item         = in_ch.payload;
    assign out_ch.valid    = out_valid;
    assign out_ch.payload  = out_item;

    fcmc_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_item      (in_item),
        .advance      (advance),
        .dec_valid_reg(dec_valid),
        .dec_reg      (dec)
    );

    fcmc_compare u_compare (
        .clk          (clk),
        .rst_n        (rst_n),
        .dec_valid    (dec_valid),
        .dec          (dec),
        .advance      (advance),
        .cmp_valid_reg(cmp_valid),
        .cmp_reg      (cmp)
    );

    fcmc_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmp_valid    (cmp_valid),
        .cmp          (cmp),
        .advance      (advance),
        .out_valid_reg(out_valid),
        .out_reg      (out_item)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ch.ready) |=> (out_valid && $stable(out_item)))
        else $error("Stalled result changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> dec_valid)
        else $error("Accepted item lost in stage one.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.fflags == 5'd0 || out_item.fflags == fcmc_pkg::FLAG_INVALID))
        else $error("Unexpected flag bits.");

endmodule
`default_nettype wire
